// ----- sv/efc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_pkg
// Shared types and constants of the evidence fusion classifier.
// ----------------------------------------------------------------------------
package efc_pkg;

    localparam logic [1:0]  CMD_ACC      = 2'd0;
    localparam logic [1:0]  CMD_LABEL    = 2'd1;
    localparam logic [1:0]  CMD_MASS     = 2'd2;

    localparam logic [1:0]  REG_SENSORS  = 2'd0;
    localparam logic [1:0]  REG_CLASSES  = 2'd1;
    localparam logic [1:0]  REG_HISTORY  = 2'd2;

    localparam logic [15:0] ONE_Q15      = 16'h8000;
    localparam logic [47:0] ONE_Q24      = 48'h100_0000;
    localparam logic [63:0] ROUND_Q24    = 64'h80_0000;
    localparam logic [15:0] TRUST_HIGH   = 16'd31130;
    localparam logic [4:0]  LABEL_NONE   = 5'd31;
    localparam logic [31:0] RECIP5       = 32'd52429;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- sv/efc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module efc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/efc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module efc_div
    import efc_pkg::*;
#(
    parameter int NW = 64,
    parameter int DW = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output div_stat_t     stat,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[NW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

// ----- sv/evidence_fusion_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evidence_fusion_classifier
// Discounts per-sensor class masses by a trust factor and fuses the sensors
// with Dempster's rule; reports the argmax class after the last sensor.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | beat
//  in      | sink      | in_valid / in_stall  | cmd, accuracy, frame_label, mass
//  out     | source    | out_valid / out_stall| class_index, total_conflict,
//          |           |                      | saturated, last
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Accuracy beats and label beats but the last are taken in the idle state.
//  The last label starts the trust step, which scans the history for labels
//  matching the newest one unless the first entry is LABEL_NONE. Each mass
//  beat passes through the shared 32x32 multiplier. Each sensor after the
//  first adds a sum pass over the classes and C divisions on the serial
//  divider; the decision adds the argmax scan and the output step.
//  Reset clears all control state; mass and label stores hold junk until
//  written. A stalled result holds; input beats are still taken until a
//  second result waits.
// ----------------------------------------------------------------------------
module evidence_fusion_classifier
    import efc_pkg::*;
#(
    parameter int MAX_CLASSES = 16,
    parameter int MAX_SOURCES = 16,
    parameter int MAX_HISTORY = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [15:0]       accuracy,
    input  logic signed [4:0] frame_label,
    input  logic [15:0]       mass,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [3:0]        class_index,
    output logic              total_conflict,
    output logic              saturated,
    output logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [4:0]        cfg_data
);

    localparam int SC_W = $clog2(MAX_SOURCES + 1);
    localparam int CI_W = $clog2(MAX_CLASSES);
    localparam int CN_W = $clog2(MAX_CLASSES + 1);
    localparam int HI_W = $clog2(MAX_HISTORY);
    localparam int HN_W = $clog2(MAX_HISTORY + 1);
    localparam int IC_W = $clog2(MAX_HISTORY + MAX_CLASSES + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_TRUST  = 5'd1;
    localparam logic [4:0] S_CNT    = 5'd2;
    localparam logic [4:0] S_TDEC   = 5'd3;
    localparam logic [4:0] S_TDIV   = 5'd4;
    localparam logic [4:0] S_M1     = 5'd5;
    localparam logic [4:0] S_M2     = 5'd6;
    localparam logic [4:0] S_M3     = 5'd7;
    localparam logic [4:0] S_M4     = 5'd8;
    localparam logic [4:0] S_M5     = 5'd9;
    localparam logic [4:0] S_ITEM   = 5'd10;
    localparam logic [4:0] S_SA_RD  = 5'd11;
    localparam logic [4:0] S_SA_ACC = 5'd12;
    localparam logic [4:0] S_Q1     = 5'd13;
    localparam logic [4:0] S_Q2     = 5'd14;
    localparam logic [4:0] S_Q3     = 5'd15;
    localparam logic [4:0] S_Q4     = 5'd16;
    localparam logic [4:0] S_F_RD   = 5'd17;
    localparam logic [4:0] S_F_MUL  = 5'd18;
    localparam logic [4:0] S_F_DIV  = 5'd19;
    localparam logic [4:0] S_F_WAIT = 5'd20;
    localparam logic [4:0] S_NEXT   = 5'd21;
    localparam logic [4:0] S_AM_RD  = 5'd22;
    localparam logic [4:0] S_AM_CMP = 5'd23;
    localparam logic [4:0] S_OUT    = 5'd24;

    logic [4:0]      state_reg, state_next;
    logic [4:0]      sensor_count_reg, sensor_count_next;
    logic [4:0]      class_count_reg, class_count_next;
    logic [3:0]      history_length_reg, history_length_next;
    logic [15:0]     acc_reg, acc_next;
    logic [15:0]     trust_reg, trust_next;
    logic [SC_W-1:0] sc_reg, sc_next;
    logic [IC_W-1:0] ic_reg, ic_next;
    logic [39:0]     nms_reg, nms_next;
    logic [39:0]     ps_reg, ps_next;
    logic [39:0]     sa_reg, sa_next;
    logic [1:0]      flags_reg, flags_next;
    logic [4:0]      hist_reg [MAX_HISTORY];
    logic [4:0]      newest_reg, newest_next;
    logic [HI_W-1:0] hi_reg, hi_next;
    logic [HN_W-1:0] same_reg, same_next;
    logic [CI_W-1:0] k_reg, k_next;
    logic [15:0]     m_reg, m_next;
    logic [33:0]     s_reg, s_next;
    logic [31:0]     b_reg, b_next;
    logic [63:0]     q_reg, q_next;
    logic [47:0]     d_reg, d_next;
    logic [31:0]     best_val_reg, best_val_next;
    logic [CI_W-1:0] best_idx_reg, best_idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [3:0]      class_index_reg, class_index_next;
    logic [1:0]      out_flags_reg, out_flags_next;
    logic [63:0]     prod_reg;

    logic [SC_W-1:0] ns;
    logic [CN_W-1:0] nc;
    logic [HN_W-1:0] hl;
    logic [IC_W-1:0] item_end;
    logic            in_acc;
    logic            hist_we;
    logic [31:0]     mul_a, mul_b;
    logic [34:0]     b_sum;
    logic [31:0]     b_new;
    logic [47:0]     lim;
    logic [9:0]      five_same, four_hl, two_hl;
    logic            fm_we, pp_we;
    logic [31:0]     fm_wdata;
    logic [31:0]     fm_rdata, pp_rdata;
    logic            div_start;
    logic [63:0]     div_num;
    div_stat_t       div_stat;
    logic [63:0]     div_quo;

    assign ns = (sensor_count_reg == 5'd0) ? SC_W'(1) :
                (32'(sensor_count_reg) > MAX_SOURCES) ? SC_W'(MAX_SOURCES) :
                SC_W'(sensor_count_reg);
    assign nc = (32'(class_count_reg) < 2) ? CN_W'(2) :
                (32'(class_count_reg) > MAX_CLASSES) ? CN_W'(MAX_CLASSES) :
                CN_W'(class_count_reg);
    assign hl = (32'(history_length_reg) < 2) ? HN_W'(2) :
                (32'(history_length_reg) > MAX_HISTORY) ? HN_W'(MAX_HISTORY) :
                HN_W'(history_length_reg);
    assign item_end = IC_W'(hl) + IC_W'(nc);

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign b_sum = 35'(s_reg) + 35'(prod_reg[33:0]) + 35'd64;
    assign b_new = 32'(b_sum >> 7);
    assign lim   = ONE_Q24 + 48'(ps_reg);
    assign five_same = 10'(same_reg) * 10'd5;
    assign four_hl   = 10'(hl) << 2;
    assign two_hl    = 10'(hl) << 1;
    assign div_num   = prod_reg + 64'(d_reg >> 1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_TDEC:
            begin
                mul_a = 32'({acc_reg, 2'b10});
                mul_b = RECIP5;
            end
            S_M1:
            begin
                mul_a = 32'({m_reg, 1'b0});
                mul_b = 32'(trust_reg);
            end
            S_M2:
            begin
                mul_a = 32'(ONE_Q15 - m_reg);
                mul_b = 32'(ONE_Q15 - trust_reg);
            end
            S_M4:
            begin
                mul_a = fm_rdata;
                mul_b = b_reg;
            end
            S_Q1:
            begin
                mul_a = 32'(sa_reg[23:0]);
                mul_b = nms_reg[31:0];
            end
            S_Q2:
            begin
                mul_a = 32'(sa_reg >> 24);
                mul_b = nms_reg[31:0];
            end
            S_F_MUL:
            begin
                mul_a = fm_rdata;
                mul_b = pp_rdata;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next          = state_reg;
        sensor_count_next   = sensor_count_reg;
        class_count_next    = class_count_reg;
        history_length_next = history_length_reg;
        acc_next            = acc_reg;
        trust_next          = trust_reg;
        sc_next             = sc_reg;
        ic_next             = ic_reg;
        nms_next            = nms_reg;
        ps_next             = ps_reg;
        sa_next             = sa_reg;
        flags_next          = flags_reg;
        newest_next         = newest_reg;
        hi_next             = hi_reg;
        same_next           = same_reg;
        k_next              = k_reg;
        m_next              = m_reg;
        s_next              = s_reg;
        b_next              = b_reg;
        q_next              = q_reg;
        d_next              = d_reg;
        best_val_next       = best_val_reg;
        best_idx_next       = best_idx_reg;
        out_valid_next      = out_valid_reg;
        class_index_next    = class_index_reg;
        out_flags_next      = out_flags_reg;
        hist_we             = 1'b0;
        fm_we               = 1'b0;
        pp_we               = 1'b0;
        fm_wdata            = b_new;
        div_start           = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SENSORS: sensor_count_next   = cfg_data;
                REG_CLASSES: class_count_next    = cfg_data;
                REG_HISTORY: history_length_next = cfg_data[3:0];
                default:     ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (cmd)
                        CMD_ACC:
                        begin
                            acc_next = (accuracy > ONE_Q15) ? ONE_Q15 : accuracy;
                            ic_next  = '0;
                            nms_next = '0;
                            ps_next  = '0;
                            if (sc_reg == '0)
                            begin
                                flags_next = '0;
                            end
                        end
                        CMD_LABEL:
                        begin
                            if (ic_reg < IC_W'(hl))
                            begin
                                hist_we = 1'b1;
                                ic_next = ic_reg + IC_W'(1);
                                if (ic_reg == IC_W'(hl) - IC_W'(1))
                                begin
                                    newest_next = frame_label;
                                    state_next  = S_TRUST;
                                end
                            end
                        end
                        CMD_MASS:
                        begin
                            if (ic_reg >= IC_W'(hl) && ic_reg < item_end)
                            begin
                                m_next     = (mass > ONE_Q15) ? ONE_Q15 : mass;
                                k_next     = CI_W'(ic_reg - IC_W'(hl));
                                state_next = S_M1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_TRUST:
            begin
                hi_next   = '0;
                same_next = '0;
                if (hist_reg[0] == LABEL_NONE)
                begin
                    trust_next = acc_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CNT;
                end
            end
            S_CNT:
            begin
                if (hist_reg[hi_reg] == newest_reg)
                begin
                    same_next = same_reg + HN_W'(1);
                end
                hi_next = hi_reg + HI_W'(1);
                if (HN_W'(hi_reg) == hl - HN_W'(2))
                begin
                    state_next = S_TDEC;
                end
            end
            S_TDEC:
            begin
                if (five_same >= four_hl)
                begin
                    trust_next = TRUST_HIGH;
                    state_next = S_IDLE;
                end
                else if (five_same <= two_hl)
                begin
                    state_next = S_TDIV;
                end
                else
                begin
                    trust_next = acc_reg;
                    state_next = S_IDLE;
                end
            end
            S_TDIV:
            begin
                trust_next = prod_reg[33:18];
                state_next = S_IDLE;
            end
            S_M1:
            begin
                state_next = S_M2;
            end
            S_M2:
            begin
                s_next     = prod_reg[33:0];
                state_next = S_M3;
            end
            S_M3:
            begin
                b_next = b_new;
                if (sc_reg == '0)
                begin
                    fm_we      = 1'b1;
                    state_next = S_ITEM;
                end
                else
                begin
                    pp_we      = 1'b1;
                    nms_next   = nms_reg + 40'(b_new);
                    state_next = S_M4;
                end
            end
            S_M4:
            begin
                state_next = S_M5;
            end
            S_M5:
            begin
                ps_next    = ps_reg + 40'((prod_reg + ROUND_Q24) >> 24);
                state_next = S_ITEM;
            end
            S_ITEM:
            begin
                ic_next = ic_reg + IC_W'(1);
                if (ic_reg + IC_W'(1) == item_end)
                begin
                    if (sc_reg != '0)
                    begin
                        k_next     = '0;
                        sa_next    = '0;
                        state_next = S_SA_RD;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SA_RD:
            begin
                state_next = S_SA_ACC;
            end
            S_SA_ACC:
            begin
                sa_next = sa_reg + 40'(fm_rdata);
                if (CN_W'(k_reg) == nc - CN_W'(1))
                begin
                    state_next = S_Q1;
                end
                else
                begin
                    k_next     = k_reg + CI_W'(1);
                    state_next = S_SA_RD;
                end
            end
            S_Q1:
            begin
                state_next = S_Q2;
            end
            S_Q2:
            begin
                q_next     = (prod_reg + ROUND_Q24) >> 24;
                state_next = S_Q3;
            end
            S_Q3:
            begin
                q_next     = q_reg + prod_reg;
                state_next = S_Q4;
            end
            S_Q4:
            begin
                if (q_reg >= 64'(lim))
                begin
                    flags_next[0] = 1'b1;
                    d_next        = ONE_Q24;
                end
                else
                begin
                    d_next = lim - q_reg[47:0];
                end
                k_next     = '0;
                state_next = S_F_RD;
            end
            S_F_RD:
            begin
                state_next = S_F_MUL;
            end
            S_F_MUL:
            begin
                state_next = S_F_DIV;
            end
            S_F_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_F_WAIT;
            end
            S_F_WAIT:
            begin
                if (div_stat.done)
                begin
                    fm_we = 1'b1;
                    if (div_quo[63:32] != '0)
                    begin
                        fm_wdata      = '1;
                        flags_next[1] = 1'b1;
                    end
                    else
                    begin
                        fm_wdata = div_quo[31:0];
                    end
                    if (CN_W'(k_reg) == nc - CN_W'(1))
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        k_next     = k_reg + CI_W'(1);
                        state_next = S_F_RD;
                    end
                end
            end
            S_NEXT:
            begin
                if (sc_reg + SC_W'(1) < ns)
                begin
                    sc_next    = sc_reg + SC_W'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    sc_next    = '0;
                    k_next     = '0;
                    state_next = S_AM_RD;
                end
            end
            S_AM_RD:
            begin
                state_next = S_AM_CMP;
            end
            S_AM_CMP:
            begin
                if (k_reg == '0 || fm_rdata > best_val_reg)
                begin
                    best_val_next = fm_rdata;
                    best_idx_next = k_reg;
                end
                if (CN_W'(k_reg) == nc - CN_W'(1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    k_next     = k_reg + CI_W'(1);
                    state_next = S_AM_RD;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    class_index_next = 4'(best_idx_reg);
                    out_flags_next   = flags_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            sensor_count_reg   <= 5'd2;
            class_count_reg    <= 5'd4;
            history_length_reg <= 4'd5;
            acc_reg            <= '0;
            trust_reg          <= '0;
            sc_reg             <= '0;
            ic_reg             <= '0;
            nms_reg            <= '0;
            ps_reg             <= '0;
            flags_reg          <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            sensor_count_reg   <= sensor_count_next;
            class_count_reg    <= class_count_next;
            history_length_reg <= history_length_next;
            acc_reg            <= acc_next;
            trust_reg          <= trust_next;
            sc_reg             <= sc_next;
            ic_reg             <= ic_next;
            nms_reg            <= nms_next;
            ps_reg             <= ps_next;
            flags_reg          <= flags_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg          <= sa_next;
        newest_reg      <= newest_next;
        hi_reg          <= hi_next;
        same_reg        <= same_next;
        k_reg           <= k_next;
        m_reg           <= m_next;
        s_reg           <= s_next;
        b_reg           <= b_next;
        q_reg           <= q_next;
        d_reg           <= d_next;
        best_val_reg    <= best_val_next;
        best_idx_reg    <= best_idx_next;
        class_index_reg <= class_index_next;
        out_flags_reg   <= out_flags_next;
        prod_reg        <= 64'(mul_a) * 64'(mul_b);
        if (hist_we)
        begin
            hist_reg[ic_reg[HI_W-1:0]] <= frame_label;
        end
    end

    efc_ram #(
        .WIDTH (32),
        .DEPTH (MAX_CLASSES)
    ) u_fused_ram (
        .clk   (clk),
        .we    (fm_we),
        .waddr (k_reg),
        .wdata (fm_wdata),
        .raddr (k_reg),
        .rdata (fm_rdata)
    );

    efc_ram #(
        .WIDTH (32),
        .DEPTH (MAX_CLASSES)
    ) u_pair_ram (
        .clk   (clk),
        .we    (pp_we),
        .waddr (k_reg),
        .wdata (b_new),
        .raddr (k_reg),
        .rdata (pp_rdata)
    );

    efc_div #(
        .NW (64),
        .DW (48)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (d_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    assign out_valid      = out_valid_reg;
    assign class_index    = class_index_reg;
    assign total_conflict = out_flags_reg[0];
    assign saturated      = out_flags_reg[1];
    assign last           = 1'b1;

    a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_F_WAIT) |-> (div_stat.busy || div_stat.done))
        else $error("division wait without a running divider");

    a_trust_range: assert property (@(posedge clk) disable iff (!rst_n)
        trust_reg <= ONE_Q15)
        else $error("trust factor above one");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    a_ic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_M1) |-> (ic_reg < item_end))
        else $error("mass beat beyond class range");

endmodule
